@@ sv/acfe_pkg.sv @@
// acfe_pkg: shared types, constants and helper functions of the antenna command frame encoder.
// No dependencies; every other file of the block imports it.
package acfe_pkg;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_WIDTH     = 19;
   localparam int ID_WIDTH        = 7;
   localparam int SEQ_WIDTH       = 7;
   localparam int BYTE_WIDTH      = 8;
   localparam int HUND_WIDTH      = 17;
   localparam int BCD_WIDTH       = 20;
   localparam int HUND_SCALE      = 100;
   localparam int PROD_WIDTH      = ANGLE_WIDTH + 7;
   localparam int CNT_WIDTH       = $clog2(HUND_WIDTH);
   localparam int IDX_WIDTH       = 5;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);

   localparam logic [SEQ_WIDTH-1:0]  SEQ_MAX  = 7'd99;
   localparam logic [ID_WIDTH-1:0]   ID_MAX   = 7'd99;
   localparam logic [HUND_WIDTH-1:0] HUND_MAX = 17'd99999;

   // byte positions inside a frame
   localparam logic [IDX_WIDTH-1:0] IDX_SEQ     = 5'd4;
   localparam logic [IDX_WIDTH-1:0] IDX_ID      = 5'd6;
   localparam logic [IDX_WIDTH-1:0] IDX_FILL    = 5'd8;
   localparam logic [IDX_WIDTH-1:0] IDX_AZ_SIGN = 5'd14;
   localparam logic [IDX_WIDTH-1:0] IDX_AZ_DIG  = 5'd15;
   localparam logic [IDX_WIDTH-1:0] IDX_EL_SIGN = 5'd20;
   localparam logic [IDX_WIDTH-1:0] IDX_EL_DIG  = 5'd21;
   localparam logic [IDX_WIDTH-1:0] IDX_LRC     = 5'd26;

   localparam logic [BYTE_WIDTH-1:0] CHAR_SYNC  = 8'h35;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ONE   = 8'h31;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_HEX_A = 8'h37;

   typedef struct packed {
      logic [7:0]           seq_bcd;
      logic [7:0]           id_bcd;
      logic                 az_negative;
      logic [BCD_WIDTH-1:0] az_bcd;
      logic                 el_negative;
      logic [BCD_WIDTH-1:0] el_bcd;
   } job_type;

   // two bcd digits of a value 0..99
   function automatic logic [7:0] dec2_bcd(input logic [SEQ_WIDTH-1:0] value);
      logic [3:0]           tens;
      logic [SEQ_WIDTH-1:0] rest;
      tens = 4'd0;
      rest = value;
      for (int t = 1; t <= 9; t++) begin
         if (value >= SEQ_WIDTH'(10 * t)) begin
            tens = 4'(t);
            rest = value - SEQ_WIDTH'(10 * t);
         end
      end
      return {tens, rest[3:0]};
   endfunction

   // hundredths of a degree, truncated and saturated
   function automatic logic [HUND_WIDTH-1:0] scale_hund(input logic [ANGLE_WIDTH-1:0] mag);
      logic [PROD_WIDTH-1:0] prod;
      logic [PROD_WIDTH-1:0] shifted;
      prod    = PROD_WIDTH'(mag) * PROD_WIDTH'(HUND_SCALE);
      shifted = prod >> ANGLE_FRAC_BITS;
      if (shifted > PROD_WIDTH'(HUND_MAX)) begin
         return HUND_MAX;
      end
      return shifted[HUND_WIDTH-1:0];
   endfunction

   // add 3 to every bcd digit of 5 or more
   function automatic logic [BCD_WIDTH-1:0] bcd_adjust(input logic [BCD_WIDTH-1:0] bcd);
      logic [BCD_WIDTH-1:0] res;
      res = bcd;
      for (int d = 0; d < BCD_WIDTH / 4; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

   // digit of a five-digit bcd word, most significant at position 0
   function automatic logic [3:0] bcd5_digit(input logic [BCD_WIDTH-1:0] bcd,
                                             input logic [2:0] pos);
      logic [3:0] dig;
      unique case (pos)
         3'd0: dig = bcd[19:16];
         3'd1: dig = bcd[15:12];
         3'd2: dig = bcd[11:8];
         3'd3: dig = bcd[7:4];
         3'd4: dig = bcd[3:0];
         default: dig = 4'd0;
      endcase
      return dig;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] digit_char(input logic [3:0] dig);
      return CHAR_ZERO | BYTE_WIDTH'(dig);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + BYTE_WIDTH'(nib);
      end
      return CHAR_HEX_A + BYTE_WIDTH'(nib);
   endfunction

endpackage

@@ sv/acfe_front.sv @@
// acfe_front: accepts a command, stamps the sequence number, scales both angles and
// converts them to bcd one bit per cycle. Depends on acfe_pkg.
module acfe_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [acfe_pkg::ID_WIDTH-1:0]         req_command_id,
   input  logic signed [acfe_pkg::ANGLE_WIDTH-1:0] req_azimuth_angle,
   input  logic signed [acfe_pkg::ANGLE_WIDTH-1:0] req_elevation_angle,
   output logic                                  job_valid,
   input  logic                                  job_ready,
   output acfe_pkg::job_type                     job
);
   import acfe_pkg::*;

   typedef enum logic [1:0] {IDLE, SCALE, CONVERT, HANDOFF} state_type;

   state_type                state_ff, state_in;
   logic [SEQ_WIDTH-1:0]     seq_ff, seq_in;
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic [7:0]               seq_bcd_ff, seq_bcd_in;
   logic [7:0]               id_bcd_ff, id_bcd_in;
   logic                     az_neg_ff, az_neg_in;
   logic                     el_neg_ff, el_neg_in;
   logic [ANGLE_WIDTH-1:0]   az_mag_ff, az_mag_in;
   logic [ANGLE_WIDTH-1:0]   el_mag_ff, el_mag_in;
   logic [HUND_WIDTH-1:0]    az_bin_ff, az_bin_in;
   logic [HUND_WIDTH-1:0]    el_bin_ff, el_bin_in;
   logic [BCD_WIDTH-1:0]     az_bcd_ff, az_bcd_in;
   logic [BCD_WIDTH-1:0]     el_bcd_ff, el_bcd_in;
   logic [BCD_WIDTH-1:0]     az_adj, el_adj;
   logic [SEQ_WIDTH-1:0]     seq_print;
   logic [ID_WIDTH-1:0]      id_sat;

   always_comb begin
      state_in   = state_ff;
      seq_in     = seq_ff;
      count_in   = count_ff;
      seq_bcd_in = seq_bcd_ff;
      id_bcd_in  = id_bcd_ff;
      az_neg_in  = az_neg_ff;
      el_neg_in  = el_neg_ff;
      az_mag_in  = az_mag_ff;
      el_mag_in  = el_mag_ff;
      az_bin_in  = az_bin_ff;
      el_bin_in  = el_bin_ff;
      az_bcd_in  = az_bcd_ff;
      el_bcd_in  = el_bcd_ff;
      az_adj     = bcd_adjust(az_bcd_ff);
      el_adj     = bcd_adjust(el_bcd_ff);
      seq_print  = (seq_ff > SEQ_MAX) ? '0 : seq_ff;
      id_sat     = (req_command_id > ID_MAX) ? ID_MAX : req_command_id;
      unique case (state_ff)
         IDLE: begin
            if (req_push) begin
               seq_bcd_in = dec2_bcd(seq_print);
               seq_in     = (seq_print >= SEQ_MAX) ? '0 : seq_print + SEQ_WIDTH'(1);
               id_bcd_in  = dec2_bcd(id_sat);
               az_neg_in  = req_azimuth_angle[ANGLE_WIDTH-1];
               el_neg_in  = req_elevation_angle[ANGLE_WIDTH-1];
               az_mag_in  = req_azimuth_angle[ANGLE_WIDTH-1] ?
                            ~req_azimuth_angle + ANGLE_WIDTH'(1) : req_azimuth_angle;
               el_mag_in  = req_elevation_angle[ANGLE_WIDTH-1] ?
                            ~req_elevation_angle + ANGLE_WIDTH'(1) : req_elevation_angle;
               state_in   = SCALE;
            end
         end
         SCALE: begin
            az_bin_in = scale_hund(az_mag_ff);
            el_bin_in = scale_hund(el_mag_ff);
            az_bcd_in = '0;
            el_bcd_in = '0;
            count_in  = '0;
            state_in  = CONVERT;
         end
         CONVERT: begin
            az_bcd_in = {az_adj[BCD_WIDTH-2:0], az_bin_ff[HUND_WIDTH-1]};
            el_bcd_in = {el_adj[BCD_WIDTH-2:0], el_bin_ff[HUND_WIDTH-1]};
            az_bin_in = az_bin_ff << 1;
            el_bin_in = el_bin_ff << 1;
            count_in  = count_ff + CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(HUND_WIDTH - 1)) begin
               state_in = HANDOFF;
            end
         end
         HANDOFF: begin
            if (job_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         seq_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         count_ff <= count_in;
      end
      seq_bcd_ff <= seq_bcd_in;
      id_bcd_ff  <= id_bcd_in;
      az_neg_ff  <= az_neg_in;
      el_neg_ff  <= el_neg_in;
      az_mag_ff  <= az_mag_in;
      el_mag_ff  <= el_mag_in;
      az_bin_ff  <= az_bin_in;
      el_bin_ff  <= el_bin_in;
      az_bcd_ff  <= az_bcd_in;
      el_bcd_ff  <= el_bcd_in;
   end

   assign req_full  = (state_ff != IDLE);
   assign job_valid = (state_ff == HANDOFF);

   always_comb begin
      job.seq_bcd     = seq_bcd_ff;
      job.id_bcd      = id_bcd_ff;
      job.az_negative = az_neg_ff;
      job.az_bcd      = az_bcd_ff;
      job.el_negative = el_neg_ff;
      job.el_bcd      = el_bcd_ff;
   end

endmodule

@@ sv/acfe_queue.sv @@
// acfe_queue: two-entry job queue between the front and the byte serializer.
// Depends on acfe_pkg.
module acfe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              ready,
   input  acfe_pkg::job_type push_job,
   output logic              valid,
   input  logic              pop,
   output acfe_pkg::job_type head
);
   import acfe_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH:0]    count_ff, count_in;
   logic                   do_push, do_pop;

   assign ready   = (count_ff != (QPTR_WIDTH + 1)'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && ready;
   assign do_pop  = pop && valid;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_WIDTH + 1)'(do_push) - (QPTR_WIDTH + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/acfe_back.sv @@
// acfe_back: walks the frame of the job at the queue head one byte per beat, builds the
// lrc on the fly and holds the byte in an output register. Depends on acfe_pkg.
module acfe_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  acfe_pkg::job_type                 job,
   output logic                              job_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [acfe_pkg::BYTE_WIDTH-1:0]   rsp_frame_byte,
   output logic                              rsp_last_byte
);
   import acfe_pkg::*;

   logic [IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_WIDTH-1:0] out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic                  advance;
   logic [7:0]            lrc;
   logic [1:0]            lrc_len;
   logic [IDX_WIDTH-1:0]  k;
   logic [IDX_WIDTH-1:0]  az_pos, el_pos;
   logic [BYTE_WIDTH-1:0] cur_byte;
   logic                  cur_last;

   assign advance = job_valid && (!out_valid_ff || rsp_pop);
   assign lrc     = ~sum_ff + 8'd1;
   assign k       = idx_ff - IDX_LRC;
   assign az_pos  = idx_ff - IDX_AZ_DIG;
   assign el_pos  = idx_ff - IDX_EL_DIG;

   always_comb begin
      if (sum_ff == 8'd0) begin
         lrc_len = 2'd3;
      end else if (lrc >= 8'd16) begin
         lrc_len = 2'd2;
      end else begin
         lrc_len = 2'd1;
      end
   end

   always_comb begin
      cur_last = 1'b0;
      priority if (idx_ff < IDX_SEQ) begin
         cur_byte = CHAR_SYNC;
      end else if (idx_ff < IDX_ID) begin
         cur_byte = digit_char(idx_ff[0] ? job.seq_bcd[3:0] : job.seq_bcd[7:4]);
      end else if (idx_ff < IDX_FILL) begin
         cur_byte = digit_char(idx_ff[0] ? job.id_bcd[3:0] : job.id_bcd[7:4]);
      end else if (idx_ff < IDX_AZ_SIGN) begin
         cur_byte = CHAR_ZERO;
      end else if (idx_ff == IDX_AZ_SIGN) begin
         cur_byte = job.az_negative ? CHAR_MINUS : CHAR_PLUS;
      end else if (idx_ff < IDX_EL_SIGN) begin
         cur_byte = digit_char(bcd5_digit(job.az_bcd, az_pos[2:0]));
      end else if (idx_ff == IDX_EL_SIGN) begin
         cur_byte = job.el_negative ? CHAR_MINUS : CHAR_PLUS;
      end else if (idx_ff < IDX_LRC) begin
         cur_byte = digit_char(bcd5_digit(job.el_bcd, el_pos[2:0]));
      end else if (k < IDX_WIDTH'(lrc_len)) begin
         priority if (lrc_len == 2'd3) begin
            cur_byte = (k == '0) ? CHAR_ONE : CHAR_ZERO;
         end else if (lrc_len == 2'd2) begin
            cur_byte = (k == '0) ? hex_char(lrc[7:4]) : hex_char(lrc[3:0]);
         end else begin
            cur_byte = hex_char(lrc[3:0]);
         end
      end else if (k == IDX_WIDTH'(lrc_len)) begin
         cur_byte = CHAR_CR;
      end else begin
         cur_byte = CHAR_LF;
         cur_last = 1'b1;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = cur_last;
         idx_in       = cur_last ? '0 : idx_ff + IDX_WIDTH'(1);
         if (idx_ff == '0) begin
            sum_in = 8'd0;
         end else if (idx_ff >= IDX_SEQ && idx_ff < IDX_LRC) begin
            sum_in = sum_ff + cur_byte;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign job_pop        = advance && cur_last;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

endmodule

@@ sv/antenna_command_frame_encoder.sv @@
// antenna_command_frame_encoder: top level, front converter, job queue and byte serializer.
// Depends on acfe_pkg, acfe_front, acfe_queue and acfe_back.
//
// Usage:
//  - command channel: drive req_command_id and both angles, raise req_push; a command is
//    taken at a clock edge with req_push high and req_full low.
//  - frame channel: while rsp_empty is low, rsp_frame_byte holds the next frame byte and
//    rsp_last_byte marks the line feed that ends a frame; rsp_pop takes the beat.
//  - path: a taken command passes a scaling step, bit-serial bcd conversion of the
//    17-bit hundredths and the queue handoff before the first byte of its frame shows.
//  - frames: one frame of 29 to 31 bytes, one byte per cycle from the serializer while
//    the receiver pops every beat; the converter takes a new command only once its job
//    has gone to the queue, and a two-entry job queue lets it run ahead of the serializer.
//  - a stalled receiver holds the current byte in the output register; the serializer
//    stops, the queue fills and the front holds its job, so req_full stays high.
//  - reset: synchronous, clears the sequence number to 0 and drops all pending work.
module antenna_command_frame_encoder (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic [acfe_pkg::ID_WIDTH-1:0]           req_command_id,
   input  logic signed [acfe_pkg::ANGLE_WIDTH-1:0] req_azimuth_angle,
   input  logic signed [acfe_pkg::ANGLE_WIDTH-1:0] req_elevation_angle,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic [acfe_pkg::BYTE_WIDTH-1:0]         rsp_frame_byte,
   output logic                                    rsp_last_byte
);
   import acfe_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    front_valid;
   logic    queue_ready;
   logic    head_valid;
   logic    head_pop;

   acfe_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command_id      (req_command_id),
      .req_azimuth_angle   (req_azimuth_angle),
      .req_elevation_angle (req_elevation_angle),
      .job_valid           (front_valid),
      .job_ready           (queue_ready),
      .job                 (front_job)
   );

   acfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .ready    (queue_ready),
      .push_job (front_job),
      .valid    (head_valid),
      .pop      (head_pop),
      .head     (head_job)
   );

   acfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .job_pop        (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

@@ sv/acfe_checker.sv @@
// acfe_checker: port-level checks of the command and frame channels, bound to the top level.
// Depends on acfe_pkg and antenna_command_frame_encoder.
module acfe_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_push,
   input logic                                    req_full,
   input logic                                    rsp_empty,
   input logic                                    rsp_pop,
   input logic [acfe_pkg::BYTE_WIDTH-1:0]         rsp_frame_byte,
   input logic                                    rsp_last_byte
);
   import acfe_pkg::*;

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("frame channel not empty after reset");

   // a taken command keeps the input closed on the next cycle
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("command channel open right after a beat");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_frame_byte) && $stable(rsp_last_byte)))
      else $error("frame beat changed while stalled");

   // the last beat of a frame is a line feed and no other beat is
   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_byte == (rsp_frame_byte == CHAR_LF)))
      else $error("last flag and line feed disagree");

   // a frame that follows a finished frame opens with the sync character
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_pop && !rsp_empty && rsp_last_byte) && !$past(reset) && !rsp_empty) |->
         (rsp_frame_byte == CHAR_SYNC))
      else $error("frame does not open with sync");

endmodule

bind antenna_command_frame_encoder acfe_checker u_acfe_checker (.*);

@@ verif/antenna_command_frame_encoder_tb.sv @@
`timescale 1ns / 1ps
// antenna_command_frame_encoder_tb: self-checking testbench for the command frame encoder.
// Depends on acfe_pkg and antenna_command_frame_encoder; predicts every frame beat on its own.
module antenna_command_frame_encoder_tb;
   import acfe_pkg::*;

   localparam int          STALL_CYCLES = 400;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          FIND_TRIES   = 100000;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [BYTE_WIDTH-1:0] CHAR_HEX_ALPHA = 8'h41;

   typedef struct {
      logic [BYTE_WIDTH-1:0] frame_byte;
      logic                  last_byte;
   } frame_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic [ID_WIDTH-1:0]           req_command_id;
   logic signed [ANGLE_WIDTH-1:0] req_azimuth_angle;
   logic signed [ANGLE_WIDTH-1:0] req_elevation_angle;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic [BYTE_WIDTH-1:0]         rsp_frame_byte;
   logic                          rsp_last_byte;

   frame_beat_type                expected_beats[$];
   logic [SEQ_WIDTH-1:0]          frame_seq;
   int                            mismatches;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   logic                          rx_stall;

   antenna_command_frame_encoder i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command_id      (req_command_id),
      .req_azimuth_angle   (req_azimuth_angle),
      .req_elevation_angle (req_elevation_angle),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_last_byte       (rsp_last_byte)
   );

   always #5 clock = ~clock;

   function automatic logic [BYTE_WIDTH-1:0] decimal_char(input int unsigned value,
                                                          input int place);
      return CHAR_ZERO + BYTE_WIDTH'((value / (10 ** place)) % 10);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] hex_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + BYTE_WIDTH'(nib);
      end
      return CHAR_HEX_ALPHA + BYTE_WIDTH'(nib - 4'd10);
   endfunction

   // truncated hundredths of a degree, saturated
   function automatic int unsigned angle_hundredths(input logic signed [ANGLE_WIDTH-1:0] raw);
      int value;
      int unsigned scaled;
      value  = raw;
      scaled = ((value < 0 ? -value : value) * 100) >> ANGLE_FRAC_BITS;
      return (scaled > HUND_MAX) ? int'(HUND_MAX) : scaled;
   endfunction

   function automatic void build_frame(input logic [SEQ_WIDTH-1:0] seq,
                                       input logic [ID_WIDTH-1:0] id,
                                       input logic signed [ANGLE_WIDTH-1:0] az,
                                       input logic signed [ANGLE_WIDTH-1:0] el,
                                       output logic [BYTE_WIDTH-1:0] text[$]);
      logic signed [ANGLE_WIDTH-1:0] angles[2];
      logic [BYTE_WIDTH-1:0]         lrc_sum;
      int unsigned                   id_sat;
      int unsigned                   hund;
      int unsigned                   lrc;
      angles[0] = az;
      angles[1] = el;
      text = {};
      repeat (4) text.push_back(CHAR_SYNC);
      for (int p = 1; p >= 0; p--) text.push_back(decimal_char(seq, p));
      id_sat = (id > ID_MAX) ? int'(ID_MAX) : int'(id);
      for (int p = 1; p >= 0; p--) text.push_back(decimal_char(id_sat, p));
      repeat (6) text.push_back(CHAR_ZERO);
      for (int a = 0; a < 2; a++) begin
         text.push_back(angles[a] < 0 ? CHAR_MINUS : CHAR_PLUS);
         hund = angle_hundredths(angles[a]);
         for (int p = 4; p >= 0; p--) text.push_back(decimal_char(hund, p));
      end
      lrc_sum = '0;
      for (int i = 4; i < text.size(); i++) lrc_sum += text[i];
      lrc = 256 - lrc_sum;
      if (lrc == 256) begin
         text.push_back(CHAR_ONE);
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_ZERO);
      end else begin
         if (lrc >= 16) text.push_back(hex_ascii(4'(lrc >> 4)));
         text.push_back(hex_ascii(4'(lrc)));
      end
      text.push_back(CHAR_CR);
      text.push_back(CHAR_LF);
   endfunction

   function automatic void predict_frame(input logic [ID_WIDTH-1:0] id,
                                         input logic signed [ANGLE_WIDTH-1:0] az,
                                         input logic signed [ANGLE_WIDTH-1:0] el);
      logic [BYTE_WIDTH-1:0] text[$];
      frame_beat_type        beat;
      build_frame(frame_seq, id, az, el, text);
      foreach (text[i]) begin
         beat.frame_byte = text[i];
         beat.last_byte  = (i == text.size() - 1);
         expected_beats.push_back(beat);
      end
      frame_seq = (frame_seq >= SEQ_MAX) ? '0 : frame_seq + 1'b1;
   endfunction

   function automatic logic [ID_WIDTH-1:0] random_command_id();
      if ($urandom_range(99) < 85) begin
         return ID_WIDTH'($urandom_range(99));
      end
      return ID_WIDTH'($urandom_range(127, 100));
   endfunction

   function automatic logic signed [ANGLE_WIDTH-1:0] random_angle();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         return ANGLE_WIDTH'($urandom);
      end
      if (pick < 40) begin
         return ANGLE_WIDTH'(int'($urandom_range(1200)) - 600);
      end
      return ANGLE_WIDTH'(int'($urandom_range(512000)) - 256000);
   endfunction

   task automatic send_command(input logic [ID_WIDTH-1:0] id,
                               input logic signed [ANGLE_WIDTH-1:0] az,
                               input logic signed [ANGLE_WIDTH-1:0] el);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push            <= 1'b1;
      req_command_id      <= id;
      req_azimuth_angle   <= az;
      req_elevation_angle <= el;
      do @(posedge clock); while (req_full);
      predict_frame(id, az, el);
   endtask

   task automatic test_directed_fields();
      send_command(7'd0, 19'sd0, 19'sd0);
      send_command(7'd99, 19'sd256000, -19'sd256000);
      send_command(7'd100, 19'sd12345, -19'sd6789);
      send_command(7'd127, 19'sd262143, -19'sd262144);
      send_command(7'h55, -19'sd1, -19'sd2);
      send_command(7'h2A, 19'sd1, 19'sd3);
      send_command(7'd42, 19'sd255997, -19'sd255997);
      send_command(7'd57, 19'sd255998, -19'sd255998);
      send_command(7'd64, -19'sd255999, 19'sd256001);
      send_command(7'd1, -19'sd131072, 19'sd131071);
      send_command(7'd9, 19'sd256, -19'sd256);
      send_command(7'd10, 19'sd170000, 19'sd85000);
   endtask

   // hit the one, two and three character check fields
   task automatic test_lrc_lengths();
      logic [ID_WIDTH-1:0]           id;
      logic signed [ANGLE_WIDTH-1:0] az;
      logic signed [ANGLE_WIDTH-1:0] el;
      logic [BYTE_WIDTH-1:0]         text[$];
      int                            tries;
      for (int len = 29; len <= 31; len++) begin
         for (int n = 0; n < 2; n++) begin
            tries = 0;
            do begin
               id = random_command_id();
               az = random_angle();
               el = random_angle();
               build_frame(frame_seq, id, az, el, text);
               tries++;
            end while (text.size() != len && tries < FIND_TRIES);
            send_command(id, az, el);
         end
      end
   endtask

   task automatic test_random_commands(input int count);
      repeat (count) send_command(random_command_id(), random_angle(), random_angle());
   endtask

   // receiver holds off long enough for the queue to fill and req_full to rise
   task automatic test_full_backpressure();
      fork
         begin
            rx_stall = 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            rx_stall = 1'b0;
         end
         test_random_commands(12);
      join
   endtask

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= !rx_stall && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : frame_check
      frame_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("beat with no frame pending: byte %h last %b",
                        rsp_frame_byte, rsp_last_byte);
            end
         end else begin
            want = expected_beats.pop_front();
            if (want.frame_byte !== rsp_frame_byte || want.last_byte !== rsp_last_byte) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("frame beat mismatch: expected byte %h last %b, got byte %h last %b",
                           want.frame_byte, want.last_byte, rsp_frame_byte, rsp_last_byte);
               end
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_push            = 1'b0;
      req_command_id      = '0;
      req_azimuth_angle   = '0;
      req_elevation_angle = '0;
      rx_stall            = 1'b0;
      mismatches          = 0;
      frame_seq           = '0;
      send_idle_pct       = 28;
      recv_idle_pct       = 46;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_fields();
      test_lrc_lengths();
      test_random_commands(30);

      send_idle_pct = 46;
      recv_idle_pct = 28;
      test_random_commands(30);
      test_full_backpressure();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_commands(40);

      @(negedge clock);
      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += expected_beats.size();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
